[src/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// bpc_pkg
// shared types and constants of the button press classifier
// ----------------------------------------------------------------------------
package bpc_pkg;

  // configuration register widths
  localparam int CFG_W     = 24;
  localparam int POLL_W    = 16;
  localparam int CFG_IDX_W = 3;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEAD_TIME      = 3'd0,
    CFG_POLL_INTERVAL  = 3'd1,
    CFG_ACTIVE_LEVEL   = 3'd2,
    CFG_REPEAT_ENABLE  = 3'd3,
    CFG_REPEAT_DELAY   = 3'd4,
    CFG_REPEAT_PERIOD  = 3'd5,
    CFG_LONG_THRESHOLD = 3'd6
  } cfg_index_t;

  // register reset values
  localparam logic [CFG_W-1:0]  RST_DEAD_TIME      = 24'd0;
  localparam logic [POLL_W-1:0] RST_POLL_INTERVAL  = 16'd10000;
  localparam logic              RST_ACTIVE_LEVEL   = 1'b0;
  localparam logic              RST_REPEAT_ENABLE  = 1'b0;
  localparam logic [CFG_W-1:0]  RST_REPEAT_DELAY   = 24'd500000;
  localparam logic [CFG_W-1:0]  RST_REPEAT_PERIOD  = 24'd250000;
  localparam logic [CFG_W-1:0]  RST_LONG_THRESHOLD = 24'd1000000;

  typedef enum logic [1:0] {
    EV_PRESSED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_CLICKED  = 2'd2,
    EV_LONG     = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CFG_W-1:0]  dead_time;
    logic [POLL_W-1:0] poll_interval;
    logic              active_level;
    logic              repeat_enable;
    logic [CFG_W-1:0]  repeat_delay;
    logic [CFG_W-1:0]  repeat_period;
    logic [CFG_W-1:0]  long_threshold;
  } cfg_t;

  // events produced by one tick, in order
  typedef struct packed {
    logic [1:0] num;
    event_t     ev0;
    event_t     ev1;
  } ev_pair_t;

  typedef struct packed {
    event_t code;
    logic   last;
  } out_entry_t;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_ROOM  = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

endpackage

[src/bpc_if.sv]
// ----------------------------------------------------------------------------
// bpc_if
// valid/ready channels for poll ticks and for events
// ----------------------------------------------------------------------------
interface bpc_tick_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink (input valid, input pin_level, output ready);
endinterface

interface bpc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_code;
  logic       last_event;

  modport source (output valid, output event_code, output last_event, input ready);
  modport sink (input valid, input event_code, input last_event, output ready);
endinterface

[src/bpc_classify.sv]
// ----------------------------------------------------------------------------
// bpc_classify
// next button phase, timers and events for one poll tick
// ----------------------------------------------------------------------------
module bpc_classify #(
  parameter int TIME_BITS = 24
) (
  input  bpc_pkg::cfg_t     cfg,
  input  logic              pin_level,
  input  bpc_pkg::phase_t   phase,
  input  logic [TIME_BITS-1:0] held_time,
  input  logic [TIME_BITS-1:0] repeat_time,
  output bpc_pkg::phase_t   phase_next,
  output logic [TIME_BITS-1:0] held_time_next,
  output logic [TIME_BITS-1:0] repeat_time_next,
  output bpc_pkg::ev_pair_t evs
);

  localparam int CMP_W = (TIME_BITS > bpc_pkg::CFG_W) ? TIME_BITS : bpc_pkg::CFG_W;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [bpc_pkg::POLL_W-1:0] d);
    logic [TIME_BITS:0] s;
    s = {1'b0, t} + (TIME_BITS+1)'(d);
    sat_add = s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

  function automatic logic time_ge(input logic [TIME_BITS-1:0] t,
                                   input logic [bpc_pkg::CFG_W-1:0] lim);
    time_ge = CMP_W'(t) >= CMP_W'(lim);
  endfunction

  logic                 down;
  logic                 in_dead;
  logic [TIME_BITS-1:0] held_inc;
  logic [TIME_BITS-1:0] rep_inc;
  logic                 click;

  assign down     = (pin_level == cfg.active_level);
  assign in_dead  = (phase == bpc_pkg::PH_PRESSED) && !time_ge(held_time, cfg.dead_time);
  assign held_inc = sat_add(held_time, cfg.poll_interval);
  assign rep_inc  = sat_add(repeat_time, cfg.poll_interval);
  // short press that never started repeating
  assign click    = (phase == bpc_pkg::PH_PRESSED) &&
                    !(cfg.repeat_enable && time_ge(held_time, cfg.repeat_delay));

  always_comb begin
    phase_next       = phase;
    held_time_next   = held_time;
    repeat_time_next = repeat_time;
    evs.num          = 2'd0;
    evs.ev0          = bpc_pkg::EV_PRESSED;
    evs.ev1          = bpc_pkg::EV_CLICKED;
    if (in_dead) begin
      held_time_next = held_inc;
    end else if (down) begin
      if (phase == bpc_pkg::PH_RELEASED) begin
        phase_next       = bpc_pkg::PH_PRESSED;
        held_time_next   = '0;
        repeat_time_next = '0;
        evs.num          = 2'd1;
        evs.ev0          = bpc_pkg::EV_PRESSED;
      end else begin
        held_time_next = held_inc;
        if (cfg.repeat_enable) begin
          if (time_ge(held_inc, cfg.repeat_delay)) begin
            repeat_time_next = rep_inc;
            if (time_ge(rep_inc, cfg.repeat_period)) begin
              repeat_time_next = '0;
              evs.num          = 2'd1;
              evs.ev0          = bpc_pkg::EV_CLICKED;
            end
          end
        end else if (phase == bpc_pkg::PH_PRESSED &&
                     time_ge(held_inc, cfg.long_threshold)) begin
          phase_next = bpc_pkg::PH_LONG;
          evs.num    = 2'd1;
          evs.ev0    = bpc_pkg::EV_LONG;
        end
      end
    end else if (phase != bpc_pkg::PH_RELEASED) begin
      phase_next = bpc_pkg::PH_RELEASED;
      evs.ev0    = bpc_pkg::EV_RELEASED;
      evs.num    = click ? 2'd2 : 2'd1;
    end
  end

endmodule

[src/bpc_out_queue.sv]
// ----------------------------------------------------------------------------
// bpc_out_queue
// small result queue, takes up to two events a cycle, hands out one
// ----------------------------------------------------------------------------
module bpc_out_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bpc_pkg::ev_pair_t  evs,
  output logic               room,
  bpc_event_if.source        event_ch
);

  bpc_pkg::out_entry_t               entries [bpc_pkg::QUEUE_DEPTH];
  logic [bpc_pkg::PTR_W-1:0]         rd_ptr;
  logic [bpc_pkg::PTR_W-1:0]         wr_ptr;
  logic [bpc_pkg::COUNT_W-1:0]       count;
  logic [1:0]                        push_num;
  logic                              pop;

  assign push_num = push ? evs.num : 2'd0;
  assign pop      = event_ch.valid && event_ch.ready;
  // room for the most events one tick can cause
  assign room     = count <= bpc_pkg::COUNT_W'(bpc_pkg::QUEUE_DEPTH - bpc_pkg::QUEUE_ROOM);

  assign event_ch.valid      = count != '0;
  assign event_ch.event_code = entries[rd_ptr].code;
  assign event_ch.last_event = entries[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + bpc_pkg::PTR_W'(pop);
      wr_ptr <= wr_ptr + bpc_pkg::PTR_W'(push_num);
      count  <= count + bpc_pkg::COUNT_W'(push_num) - bpc_pkg::COUNT_W'(pop);
    end
    if (push_num != 2'd0) begin
      entries[wr_ptr] <= '{code: evs.ev0, last: (push_num == 2'd1)};
    end
    if (push_num == 2'd2) begin
      entries[wr_ptr + bpc_pkg::PTR_W'(1)] <= '{code: evs.ev1, last: 1'b1};
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= bpc_pkg::COUNT_W'(bpc_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push && evs.num != 2'd0 |-> $past(1'b1) && room)
    else $error("events pushed without room");

endmodule

[src/button_press_classifier_core.sv]
// ----------------------------------------------------------------------------
// button_press_classifier_core
// debounce, long press and autorepeat classifier for a polled button pin
// ----------------------------------------------------------------------------
//  channel    dir  handshake      payload
//  tick_ch    in   valid/ready    pin_level
//  event_ch   out  valid/ready    event_code, last_event
//  cfg        in   cfg_we         cfg_index, cfg_data (no back-pressure)
//
//  a tick waits in the input register, then the classifier updates
//  phase and timers and pushes 0, 1 or 2 events into the result queue
//  one tick per cycle while the queue has room; a tick that causes two events
//  limits the rate to the queue's single event read port (one event per cycle)
//  the input register moves on only while the queue has room for two events
//  synchronous reset: phase released, timers zero, registers at defaults,
//  queue empty
// ----------------------------------------------------------------------------
module button_press_classifier_core #(
  parameter int TIME_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpc_pkg::CFG_W-1:0]        cfg_data,
  bpc_tick_if.sink                         tick_ch,
  bpc_event_if.source                      event_ch
);

  // configuration registers
  bpc_pkg::cfg_t cfg;

  // input register
  logic stage_valid;
  logic stage_pin;
  logic stage_fire;
  logic queue_room;

  // button state
  bpc_pkg::phase_t      phase;
  logic [TIME_BITS-1:0] held_time;
  logic [TIME_BITS-1:0] repeat_time;
  bpc_pkg::phase_t      phase_next;
  logic [TIME_BITS-1:0] held_time_next;
  logic [TIME_BITS-1:0] repeat_time_next;
  bpc_pkg::ev_pair_t    evs;

  // staged tick is classified once the queue can take its events
  assign stage_fire    = stage_valid && queue_room;
  assign tick_ch.ready = !stage_valid || stage_fire;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_time      <= bpc_pkg::RST_DEAD_TIME;
      cfg.poll_interval  <= bpc_pkg::RST_POLL_INTERVAL;
      cfg.active_level   <= bpc_pkg::RST_ACTIVE_LEVEL;
      cfg.repeat_enable  <= bpc_pkg::RST_REPEAT_ENABLE;
      cfg.repeat_delay   <= bpc_pkg::RST_REPEAT_DELAY;
      cfg.repeat_period  <= bpc_pkg::RST_REPEAT_PERIOD;
      cfg.long_threshold <= bpc_pkg::RST_LONG_THRESHOLD;
    end else if (cfg_we) begin
      case (bpc_pkg::cfg_index_t'(cfg_index))
        bpc_pkg::CFG_DEAD_TIME:      cfg.dead_time      <= cfg_data;
        bpc_pkg::CFG_POLL_INTERVAL:  cfg.poll_interval  <= cfg_data[bpc_pkg::POLL_W-1:0];
        bpc_pkg::CFG_ACTIVE_LEVEL:   cfg.active_level   <= cfg_data[0];
        bpc_pkg::CFG_REPEAT_ENABLE:  cfg.repeat_enable  <= cfg_data[0];
        bpc_pkg::CFG_REPEAT_DELAY:   cfg.repeat_delay   <= cfg_data;
        bpc_pkg::CFG_REPEAT_PERIOD:  cfg.repeat_period  <= cfg_data;
        bpc_pkg::CFG_LONG_THRESHOLD: cfg.long_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register, refilled in the cycle it empties
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (tick_ch.ready) begin
      stage_valid <= tick_ch.valid;
    end
    if (tick_ch.valid && tick_ch.ready) begin
      stage_pin <= tick_ch.pin_level;
    end
  end

  bpc_classify #(
    .TIME_BITS (TIME_BITS)
  ) u_classify (
    .cfg              (cfg),
    .pin_level        (stage_pin),
    .phase            (phase),
    .held_time        (held_time),
    .repeat_time      (repeat_time),
    .phase_next       (phase_next),
    .held_time_next   (held_time_next),
    .repeat_time_next (repeat_time_next),
    .evs              (evs)
  );

  // button state advances once per classified tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= bpc_pkg::PH_RELEASED;
      held_time   <= '0;
      repeat_time <= '0;
    end else if (stage_fire) begin
      phase       <= phase_next;
      held_time   <= held_time_next;
      repeat_time <= repeat_time_next;
    end
  end

  bpc_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (stage_fire),
    .evs      (evs),
    .room     (queue_room),
    .event_ch (event_ch)
  );

  // accepted tick lands in the input register
  a_stage_load: assert property (@(posedge clk) disable iff (rst)
    tick_ch.valid && tick_ch.ready |=> stage_valid && stage_pin == $past(tick_ch.pin_level))
    else $error("accepted tick not staged");

  // a stalled tick, the phase and the held time hold
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_fire |=> stage_valid && $stable(stage_pin) && $stable(phase)
      && $stable(held_time))
    else $error("stalled tick or state changed");

  // two events come only from a release
  a_two_release: assert property (@(posedge clk) disable iff (rst)
    stage_fire && evs.num == 2'd2 |-> evs.ev0 == bpc_pkg::EV_RELEASED
      && phase_next == bpc_pkg::PH_RELEASED)
    else $error("event pair not from a release");

endmodule
